FILE: rtl/assert_macros.svh
// Assertion macros used by the checker module.
// Each macro clocks on the rising edge and is quiet while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/lai_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lai_pkg;

	// Table depth and the widths that follow from it.
	localparam int MAX_ANCHORS = 256;
	localparam int IDX_W = $clog2(MAX_ANCHORS);
	localparam int CNT_W = $clog2(MAX_ANCHORS + 1);

	// Fixed field widths.
	localparam int REQ_TYPE_W     = 2;
	localparam int OFFSET_W       = 32;
	localparam int LINE_W         = 32;
	localparam int BLOCK_INDEX_W  = 8;
	localparam int ANCHOR_COUNT_W = 9;
	localparam int CAP_W          = 9;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 32;
	localparam int LIM_W          = (CAP_W > CNT_W) ? CAP_W : CNT_W;

	// Register reset values.
	localparam int CAP_RESET       = 256;
	localparam int MIN_BYTES_RESET = 2048;
	localparam int MIN_LINES_RESET = 1024;
	localparam int LIMIT_RESET     = (CAP_RESET < MAX_ANCHORS) ? CAP_RESET : MAX_ANCHORS;
	localparam int HELD_RESET      = (LIMIT_RESET > 0) ? 1 : 0;

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_BREAK  = 2'd0,
		REQ_FINISH = 2'd1,
		REQ_FIND   = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_CAPACITY  = 2'd0,
		CFG_MIN_BYTES = 2'd1,
		CFG_MIN_LINES = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE   = 1'b0,
		ST_SEARCH = 1'b1
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/lai_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one word per break, finish, find or clear.
interface lai_req_if import lai_pkg::*; ;
	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [OFFSET_W-1:0]   byte_offset;
	logic [LINE_W-1:0]     line_number;

	modport source (output valid, req_type, byte_offset, line_number, input ready);
	modport sink (input valid, req_type, byte_offset, line_number, output ready);
endinterface

// Response channel: one word per request.
interface lai_rsp_if import lai_pkg::*; ;
	logic                      valid;
	logic                      ready;
	logic                      found;
	logic [BLOCK_INDEX_W-1:0]  block_index;
	logic [ANCHOR_COUNT_W-1:0] anchor_count;

	modport source (output valid, found, block_index, anchor_count, input ready);
	modport sink (input valid, found, block_index, anchor_count, output ready);
endinterface

// Register write channel.
interface lai_cfg_if import lai_pkg::*; ;
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/lai_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lai_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/line_anchor_index_with_search.sv
// Sparse line-anchor index for a large text file, with a binary-search lookup.
// Requests arrive on the req channel as words (req_type, byte_offset, line_number):
// a line break, a finish, a find or a clear. Every accepted request gives exactly
// one response word on the rsp channel (found, block_index, anchor_count).
// Register writes come on the cfg channel, which is always ready; write them only
// while the block is idle.
// Break, finish and clear complete in the cycle they are accepted; the response
// shows in the cycle after. A find that is not rejected makes one table probe per
// cycle after the accept cycle, at most log2(anchors held) + 1 probes, before the
// response shows. The single read port of the anchor-line memory and its
// registered output set that pace: the probe read in one cycle is compared in the
// next, which also issues the following read.
// The block takes a new request only while no search runs and the response
// register is empty or being emptied in that same cycle, so a stalled receiver
// holds off new requests and a response is never overwritten.
// After reset the table holds the head anchor (0,0), the running line total is 0
// and the registers hold capacity 256, 2048 bytes and 1024 lines.
`timescale 1ns / 1ps
`default_nettype none

module line_anchor_index_with_search import lai_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	lai_req_if.sink   req,
	lai_rsp_if.source rsp,
	lai_cfg_if.sink   cfg
);

	// Configuration registers.
	logic [CAP_W-1:0]    cap_q;
	logic [OFFSET_W-1:0] min_bytes_q;
	logic [LINE_W-1:0]   min_lines_q;

	// Index state.
	logic [CNT_W-1:0]    held_q, held_d;
	logic [OFFSET_W-1:0] last_off_q, last_off_d;
	logic [LINE_W-1:0]   last_line_q, last_line_d;
	logic [LINE_W-1:0]   lines_q, lines_d;
	logic                fin_q, fin_d;
	logic                head_wr_q;

	// Sequencer and search registers.
	state_t              state_q, state_d;
	logic [CNT_W-1:0]    lo_q, lo_d, hi_q, hi_d;
	logic [IDX_W-1:0]    mid_q, mid_d, idx_q, idx_d;
	logic [LINE_W-1:0]   key_q, key_d;
	logic                hit_q, hit_d;

	// Response register.
	logic                out_valid_q;
	logic                out_found_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic [CNT_W-1:0]    out_count_q;

	// Combinational control.
	logic                in_ready;
	logic                req_acc;
	req_kind_t           kind;
	logic [LIM_W-1:0]    limit;
	logic                room;
	logic                dist_ok;
	logic                append;
	logic                ram_re;
	logic [IDX_W-1:0]    ram_raddr;
	logic [LINE_W-1:0]   ram_rdata;
	logic [LINE_W-1:0]   probe_line;
	logic                le;
	logic [CNT_W-1:0]    lo_nx, hi_nx;
	logic [CNT_W:0]      mid_sum;
	logic [CNT_W-1:0]    mid_full;
	logic [IDX_W-1:0]    mid_nx;
	logic [CNT_W-1:0]    start_mid;
	logic                load;
	logic                ld_found;
	logic [IDX_W-1:0]    ld_idx;

	assign req_acc = req.valid && in_ready;
	assign req.ready = in_ready;
	assign kind = req_kind_t'(req.req_type);
	assign cfg.ready = 1'b1;

	// The limit in force is the smaller of the capacity register and the table depth.
	assign limit = (LIM_W'(cap_q) < LIM_W'(MAX_ANCHORS)) ? LIM_W'(cap_q) : LIM_W'(MAX_ANCHORS);
	assign room = LIM_W'(held_q) < limit;

	// Distances wrap modulo 2^32, as unsigned differences.
	assign dist_ok = ((req.byte_offset - last_off_q) >= min_bytes_q) &&
	                 ((req.line_number - last_line_q) >= min_lines_q);

	// The head entry is never written after reset, so it reads as zero until a
	// clear lets an append write it.
	assign probe_line = ((mid_q == '0) && !head_wr_q) ? '0 : ram_rdata;
	assign le = probe_line <= key_q;

	// One bisection step: move the low bound past a hit, else pull the high bound in.
	assign lo_nx = le ? (CNT_W'(mid_q) + CNT_W'(1)) : lo_q;
	assign hi_nx = le ? hi_q : CNT_W'(mid_q);
	assign mid_sum = {1'b0, lo_nx} + {1'b0, hi_nx};
	assign mid_full = mid_sum[CNT_W:1];
	assign mid_nx = mid_full[IDX_W-1:0];
	assign start_mid = held_q >> 1;

	lai_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_ANCHORS)
	) u_lines (
		.clk  (clk),
		.we   (append),
		.waddr(held_q[IDX_W-1:0]),
		.wdata(req.line_number),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		held_d      = held_q;
		last_off_d  = last_off_q;
		last_line_d = last_line_q;
		lines_d     = lines_q;
		fin_d       = fin_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		mid_d       = mid_q;
		key_d       = key_q;
		hit_d       = hit_q;
		idx_d       = idx_q;
		append      = 1'b0;
		ram_re      = 1'b0;
		ram_raddr   = mid_nx;
		load        = 1'b0;
		ld_found    = 1'b0;
		ld_idx      = '0;
		in_ready    = 1'b0;

		case (state_q)
			ST_IDLE: begin
				in_ready = !out_valid_q || rsp.ready;
				if (req_acc) begin
					case (kind)
						REQ_BREAK: begin
							lines_d = req.line_number;
							load = 1'b1;
							if (room && dist_ok) begin
								append = 1'b1;
								held_d = held_q + CNT_W'(1);
								last_off_d = req.byte_offset;
								last_line_d = req.line_number;
							end
						end
						REQ_FINISH: begin
							load = 1'b1;
							// A repeated finish only reports the count.
							if (!fin_q) begin
								fin_d = 1'b1;
								lines_d = req.line_number;
								if (room) begin
									append = 1'b1;
									held_d = held_q + CNT_W'(1);
								end
							end
						end
						REQ_FIND: begin
							// Rejected when the table is empty or the key is at or past the total.
							if ((held_q != '0) && (req.line_number < lines_q)) begin
								ram_re = 1'b1;
								ram_raddr = start_mid[IDX_W-1:0];
								mid_d = start_mid[IDX_W-1:0];
								lo_d = '0;
								hi_d = held_q;
								key_d = req.line_number;
								hit_d = 1'b0;
								idx_d = '0;
								state_d = ST_SEARCH;
							end else begin
								load = 1'b1;
							end
						end
						REQ_CLEAR: begin
							held_d = '0;
							lines_d = '0;
							last_off_d = '0;
							last_line_d = '0;
							fin_d = 1'b0;
							load = 1'b1;
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			ST_SEARCH: begin
				lo_d = lo_nx;
				hi_d = hi_nx;
				hit_d = hit_q || le;
				idx_d = le ? mid_q : idx_q;
				if (lo_nx < hi_nx) begin
					ram_re = 1'b1;
					mid_d = mid_nx;
				end else begin
					load = 1'b1;
					ld_found = hit_q || le;
					ld_idx = le ? mid_q : idx_q;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration and index state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_W'(CAP_RESET);
			min_bytes_q <= OFFSET_W'(MIN_BYTES_RESET);
			min_lines_q <= LINE_W'(MIN_LINES_RESET);
			held_q      <= CNT_W'(HELD_RESET);
			last_off_q  <= '0;
			last_line_q <= '0;
			lines_q     <= '0;
			fin_q       <= 1'b0;
			head_wr_q   <= 1'b0;
		end else begin
			held_q      <= held_d;
			last_off_q  <= last_off_d;
			last_line_q <= last_line_d;
			lines_q     <= lines_d;
			fin_q       <= fin_d;
			if (append && (held_q[IDX_W-1:0] == '0)) begin
				head_wr_q <= 1'b1;
			end
			if (cfg.valid) begin
				case (cfg.index)
					CFG_CAPACITY:  cap_q <= cfg.data[CAP_W-1:0];
					CFG_MIN_BYTES: min_bytes_q <= cfg.data[OFFSET_W-1:0];
					CFG_MIN_LINES: min_lines_q <= cfg.data[LINE_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Search working registers carry no reset; they are loaded when a find starts.
	always_ff @(posedge clk) begin
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		mid_q <= mid_d;
		key_q <= key_d;
		hit_q <= hit_d;
		idx_q <= idx_d;
	end

	// Response register: filled once per request, emptied when the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_found_q <= ld_found;
			out_idx_q   <= ld_idx;
			out_count_q <= held_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.found        = out_found_q;
	assign rsp.block_index  = BLOCK_INDEX_W'(out_idx_q);
	assign rsp.anchor_count = ANCHOR_COUNT_W'(out_count_q);

endmodule

`default_nettype wire

FILE: rtl/lai_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lai_checker import lai_pkg::*; (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      req_valid,
	input wire logic                      req_ready,
	input wire logic [REQ_TYPE_W-1:0]     req_type,
	input wire logic                      rsp_valid,
	input wire logic                      rsp_ready,
	input wire logic                      rsp_found,
	input wire logic [BLOCK_INDEX_W-1:0]  rsp_block_index,
	input wire logic [ANCHOR_COUNT_W-1:0] rsp_anchor_count
);

	logic req_acc;
	logic quick_req;

	assign req_acc = req_valid && req_ready;
	assign quick_req = req_type != REQ_FIND;

	// A new request never lands on a response that is still waiting.
	`ASSERT_SAME(a_no_overwrite, clk, arst_n, req_acc, !(rsp_valid && !rsp_ready))
	// Break, finish and clear answer in the next cycle.
	`ASSERT_NEXT(a_quick_reply, clk, arst_n, req_acc && quick_req, rsp_valid)
	// A clear leaves the table empty.
	`ASSERT_NEXT(a_clear_empty, clk, arst_n, req_acc && (req_type == REQ_CLEAR), rsp_anchor_count == '0)
	// A miss reports index zero.
	`ASSERT_SAME(a_miss_index, clk, arst_n, rsp_valid && !rsp_found, rsp_block_index == '0)

endmodule

bind line_anchor_index_with_search lai_checker u_lai_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_type        (req.req_type),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_found       (rsp.found),
	.rsp_block_index (rsp.block_index),
	.rsp_anchor_count(rsp.anchor_count)
);

`default_nettype wire

FILE: sim/tb_line_anchor_index_with_search.sv
`timescale 1ns / 1ps

module tb_line_anchor_index_with_search;
	import lai_pkg::*;

	// One request word as the testbench sees it, and the response it should draw.
	typedef struct packed {
		req_kind_t           kind;
		logic [OFFSET_W-1:0] offset;
		logic [LINE_W-1:0]   line;
	} lai_req_t;

	typedef struct packed {
		logic                      found;
		logic [BLOCK_INDEX_W-1:0]  index;
		logic [ANCHOR_COUNT_W-1:0] count;
	} lai_rsp_t;

	localparam int CYCLE_LIMIT = 300000;
	localparam int MAX_PRINTED = 100;

	logic clk;
	logic arst_n;

	lai_req_if req ();
	lai_rsp_if rsp ();
	lai_cfg_if cfg ();

	line_anchor_index_with_search dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	// Our own copy of the anchor table and the registers. The table is only ever
	// read below anchors_held, so entries that were never written do not matter.
	logic [OFFSET_W-1:0]   anchor_off [MAX_ANCHORS];
	logic [LINE_W-1:0]     anchor_line [MAX_ANCHORS];
	int unsigned           anchors_held;
	logic [OFFSET_W-1:0]   last_off;
	logic [LINE_W-1:0]     last_line;
	logic [LINE_W-1:0]     line_total;
	bit                    file_finished;
	logic [CAP_W-1:0]      cap_reg;
	logic [CFG_DATA_W-1:0] min_bytes_reg;
	logic [CFG_DATA_W-1:0] min_lines_reg;

	// Words waiting to be sent, and responses waiting to come back.
	lai_req_t req_backlog [$];
	lai_rsp_t awaited_rsp [$];

	lai_req_t shown_req;
	lai_rsp_t next_rsp;
	lai_rsp_t want_rsp;
	bit       word_shown;

	int send_gap_pct;
	int recv_stall_pct;
	int mismatches;
	int words_taken;
	int rsp_checked;
	int find_hits;
	int peak_held;
	int reg_settings;
	int cycles;

	// Running position of the synthetic file that the random scans walk through.
	logic [OFFSET_W-1:0] scan_off;
	logic [LINE_W-1:0]   scan_line;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Works out the response to one accepted word and moves our table along.
	task automatic step_anchor_index(input lai_req_t r, output lai_rsp_t o);
		int unsigned         limit;
		int unsigned         lo;
		int unsigned         hi;
		int unsigned         mid;
		logic [OFFSET_W-1:0] byte_gap;
		logic [LINE_W-1:0]   line_gap;
		bit                  room;
		limit = (cap_reg < MAX_ANCHORS) ? cap_reg : MAX_ANCHORS;
		room = anchors_held < limit;
		o = '0;
		case (r.kind)
			REQ_BREAK: begin
				// Distances are taken modulo 2^32, so a wrapped offset still counts.
				line_total = r.line;
				byte_gap = r.offset - last_off;
				line_gap = r.line - last_line;
				if (room && byte_gap >= min_bytes_reg && line_gap >= min_lines_reg) begin
					anchor_off[anchors_held] = r.offset;
					anchor_line[anchors_held] = r.line;
					anchors_held++;
					last_off = r.offset;
					last_line = r.line;
				end
			end
			REQ_FINISH: begin
				// Only the first finish counts. The sentinel leaves the last anchor alone.
				if (!file_finished) begin
					file_finished = 1'b1;
					line_total = r.line;
					if (room) begin
						anchor_off[anchors_held] = r.offset;
						anchor_line[anchors_held] = r.line;
						anchors_held++;
					end
				end
			end
			REQ_FIND: begin
				// Rejected on an empty table or a key at or past the line total.
				if (anchors_held != 0 && r.line < line_total) begin
					lo = 0;
					hi = anchors_held;
					while (lo < hi) begin
						mid = lo + (hi - lo) / 2;
						if (anchor_line[mid] <= r.line) begin
							o.found = 1'b1;
							o.index = mid[BLOCK_INDEX_W-1:0];
							lo = mid + 1;
						end else begin
							hi = mid;
						end
					end
				end
			end
			default: begin
				// Clear drops the head anchor too.
				anchors_held = 0;
				line_total = '0;
				last_off = '0;
				last_line = '0;
				file_finished = 1'b0;
			end
		endcase
		o.count = anchors_held[ANCHOR_COUNT_W-1:0];
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// Writes all three registers back to back, keeping valid high between writes.
	task automatic load_regs(input logic [CAP_W-1:0] cap, input logic [CFG_DATA_W-1:0] nbytes,
			input logic [CFG_DATA_W-1:0] nlines);
		cfg_reg_t              regs [3];
		logic [CFG_DATA_W-1:0] vals [3];
		regs = '{CFG_CAPACITY, CFG_MIN_BYTES, CFG_MIN_LINES};
		vals = '{CFG_DATA_W'(cap), nbytes, nlines};
		for (int i = 0; i < 3; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= regs[i];
			cfg.data <= vals[i];
			do @(posedge clk); while (!cfg.ready);
			case (regs[i])
				CFG_CAPACITY:  cap_reg = vals[i][CAP_W-1:0];
				CFG_MIN_BYTES: min_bytes_reg = vals[i];
				default:       min_lines_reg = vals[i];
			endcase
		end
		cfg.valid <= 1'b0;
		reg_settings++;
	endtask

	task automatic push_req(input req_kind_t kind, input logic [OFFSET_W-1:0] off,
			input logic [LINE_W-1:0] line);
		lai_req_t r;
		r.kind = kind;
		r.offset = off;
		r.line = line;
		req_backlog.push_back(r);
	endtask

	// Returns once every queued word has gone out and every response has come back.
	task automatic wait_drained();
		while (req_backlog.size() != 0 || word_shown || awaited_rsp.size() != 0)
			@(posedge clk);
	endtask

	// Queues a well-formed scan: mostly line breaks that walk forward through a file,
	// with finds aimed around the current line total, some finishes and clears, and
	// a little noise with every field random.
	task automatic queue_scan(input int n, input int unsigned byte_step,
			input int unsigned line_step, input int break_pct, input bit fresh);
		int        pick;
		logic [LINE_W-1:0] key;
		if (fresh) begin
			push_req(REQ_CLEAR, $urandom, $urandom);
			scan_off = $urandom;
			scan_line = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100);
		end
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < break_pct) begin
				scan_off += $urandom_range(1, byte_step);
				scan_line += $urandom_range(1, line_step);
				push_req(REQ_BREAK, scan_off, scan_line);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 60) begin
					case ($urandom_range(0, 4))
						0: key = scan_line - $urandom_range(1, 4 * line_step + 1);
						1: key = $urandom;
						2: key = scan_line - 1;
						3: key = scan_line;
						default: key = $urandom_range(0, 3);
					endcase
					push_req(REQ_FIND, $urandom, key);
				end else if (pick < 75) begin
					push_req(REQ_FINISH, scan_off + $urandom_range(0, byte_step), scan_line);
				end else if (pick < 83) begin
					push_req(REQ_CLEAR, $urandom, $urandom);
				end else begin
					push_req(req_kind_t'($urandom_range(0, 3)), $urandom, $urandom);
				end
			end
		end
	endtask

	task automatic run_scan_phase(input logic [CAP_W-1:0] cap,
			input logic [CFG_DATA_W-1:0] nbytes, input logic [CFG_DATA_W-1:0] nlines,
			input int n, input int unsigned byte_step, input int unsigned line_step,
			input int break_pct, input bit fresh);
		load_regs(cap, nbytes, nlines);
		queue_scan(n, byte_step, line_step, break_pct, fresh);
		wait_drained();
	endtask

	// Driver: shows the oldest queued word and holds it until it is taken. Each taken
	// word is run through our table right away, so the response it should draw is
	// queued in the order the block sees the words.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.req_type <= REQ_BREAK;
			req.byte_offset <= '0;
			req.line_number <= '0;
			word_shown = 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				step_anchor_index(shown_req, next_rsp);
				awaited_rsp.push_back(next_rsp);
				words_taken++;
				word_shown = 1'b0;
			end
			if (!word_shown) begin
				if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					shown_req = req_backlog.pop_front();
					word_shown = 1'b1;
					req.valid <= 1'b1;
					req.req_type <= shown_req.kind;
					req.byte_offset <= shown_req.offset;
					req.line_number <= shown_req.line;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each response word against the oldest awaited one and stalls
	// the block at random through rsp.ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (awaited_rsp.size() == 0) begin
					report_mismatch($sformatf("response with nothing awaited (found %0d index %0d count %0d)",
						rsp.found, rsp.block_index, rsp.anchor_count));
				end else begin
					want_rsp = awaited_rsp.pop_front();
					rsp_checked++;
					if (rsp.found !== want_rsp.found)
						report_mismatch($sformatf("word %0d found: want %0d got %b",
							rsp_checked, want_rsp.found, rsp.found));
					if (rsp.block_index !== want_rsp.index)
						report_mismatch($sformatf("word %0d block_index: want %0d got %0d",
							rsp_checked, want_rsp.index, rsp.block_index));
					if (rsp.anchor_count !== want_rsp.count)
						report_mismatch($sformatf("word %0d anchor_count: want %0d got %0d",
							rsp_checked, want_rsp.count, rsp.anchor_count));
					if (want_rsp.found)
						find_hits++;
					if (want_rsp.count > peak_held)
						peak_held = want_rsp.count;
				end
			end
			rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses still awaited", cycles,
				awaited_rsp.size());
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		req.valid = 1'b0;
		req.req_type = REQ_BREAK;
		req.byte_offset = '0;
		req.line_number = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_CAPACITY;
		cfg.data = '0;
		arst_n = 1'b0;

		// Our table starts where the block does after reset: registers at their reset
		// values and the head anchor (0,0) in place.
		cap_reg = CAP_W'(256);
		min_bytes_reg = 32'd2048;
		min_lines_reg = 32'd1024;
		anchor_off[0] = '0;
		anchor_line[0] = '0;
		anchors_held = (cap_reg != 0) ? 1 : 0;
		last_off = '0;
		last_line = '0;
		line_total = '0;
		file_finished = 1'b0;
		scan_off = '0;
		scan_line = '0;

		send_gap_pct = 12;
		recv_stall_pct = 46;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, first on the reset register values. A find before any break
		// is rejected because the line total is still zero.
		push_req(REQ_FIND, 32'd0, 32'd0);
		push_req(REQ_BREAK, 32'd100, 32'd5);
		push_req(REQ_FIND, 32'd0, 32'd0);
		push_req(REQ_FIND, 32'd0, 32'd5);
		// Distances exactly at the thresholds, then the largest offset and line.
		push_req(REQ_BREAK, 32'd2048, 32'd1024);
		push_req(REQ_BREAK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_req(REQ_FIND, 32'd0, 32'hFFFF_FFFE);
		push_req(REQ_FIND, 32'd0, 32'd1023);
		// Finish adds the sentinel; a second finish changes nothing.
		push_req(REQ_FINISH, 32'd5000, 32'hFFFF_FFFF);
		push_req(REQ_FINISH, 32'd9000, 32'd7);
		// Breaks after finish, measured across the 2^32 wrap from the last anchor.
		push_req(REQ_BREAK, 32'd10, 32'd3);
		push_req(REQ_BREAK, 32'd4000, 32'd2000);
		// After clear the table is empty, so finds are rejected until an anchor lands,
		// and a key below the first anchor finds nothing.
		push_req(REQ_CLEAR, 32'd0, 32'd0);
		push_req(REQ_BREAK, 32'd100, 32'd50);
		push_req(REQ_FIND, 32'd0, 32'd10);
		push_req(REQ_BREAK, 32'd3000, 32'd1500);
		push_req(REQ_FIND, 32'd0, 32'd100);
		push_req(REQ_FIND, 32'd0, 32'd1499);
		wait_drained();

		// Smallest thresholds and a two-entry table: the third break finds it full,
		// and so does the finish.
		load_regs(CAP_W'(2), 32'd1, 32'd1);
		push_req(REQ_CLEAR, 32'd0, 32'd0);
		push_req(REQ_BREAK, 32'd1, 32'd1);
		push_req(REQ_BREAK, 32'd2, 32'd2);
		push_req(REQ_BREAK, 32'd3, 32'd3);
		push_req(REQ_FINISH, 32'd4, 32'd9);
		wait_drained();

		// Capacity lowered below the anchors held: they stay searchable, none is added.
		load_regs(CAP_W'(1), 32'd1, 32'd1);
		push_req(REQ_BREAK, 32'd10, 32'd10);
		push_req(REQ_FIND, 32'd0, 32'd5);
		wait_drained();

		// Zero capacity: nothing can ever be appended after a clear.
		load_regs(CAP_W'(0), 32'd1, 32'd1);
		push_req(REQ_CLEAR, 32'd0, 32'd0);
		push_req(REQ_FINISH, 32'd7, 32'd7);
		push_req(REQ_FIND, 32'd0, 32'd3);
		wait_drained();

		// Random scans. The third one clears and then sends nothing but breaks with the
		// smallest thresholds, so all 256 entries fill and the table-full path is hit
		// with a deep table. The fourth keeps that full table, so its finds search it
		// at full depth.
		run_scan_phase(CAP_W'(256), 32'd64, 32'd8, 60, 128, 16, 55, 1'b1);
		run_scan_phase(CAP_W'(5), 32'd1, 32'd1, 60, 8, 4, 50, 1'b1);
		send_gap_pct = 46;
		recv_stall_pct = 12;
		run_scan_phase(CAP_W'(256), 32'd1, 32'd1, 300, 4, 3, 100, 1'b1);
		// Shrink the capacity under the full table with the largest thresholds.
		run_scan_phase(CAP_W'(3), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 50, 64, 8, 50, 1'b0);
		send_gap_pct = 0;
		recv_stall_pct = 0;
		run_scan_phase(CAP_W'(0), 32'd1000, 32'd100, 50, 2000, 200, 50, 1'b1);
		run_scan_phase(CAP_W'(256), 32'd2048, 32'd1024, 30, 4096, 2048, 60, 1'b1);

		// A few more cycles in case the block sends anything it should not.
		repeat (20) @(posedge clk);

		$display("Checked %0d responses to %0d request words (%0d finds hit an anchor).",
			rsp_checked, words_taken, find_hits);
		$display("Used %0d register settings; the table peaked at %0d anchors.",
			reg_settings, peak_held);
		if (mismatches == 0 && awaited_rsp.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d responses missing", mismatches, awaited_rsp.size());
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: line_anchor_index_with_search.f
+incdir+rtl
rtl/lai_pkg.sv
rtl/lai_if.sv
rtl/lai_ram.sv
rtl/line_anchor_index_with_search.sv
rtl/lai_checker.sv
sim/tb_line_anchor_index_with_search.sv
